>>> design/ssd_pkg.sv
`default_nettype none

package ssd_pkg;

   // default widths of the sample path and the wait counter
   localparam int SAMPLE_BITS_DEF = 10;
   localparam int WAIT_BITS_DEF   = 16;

   // fixed register widths
   localparam int THRESH_W   = 10;
   localparam int SETTLE_W   = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // register reset values
   localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(512);
   localparam logic [SETTLE_W-1:0] SETTLE_RST = SETTLE_W'(20);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESS_THRESHOLD = 1'b0,
      CSR_SETTLE_TICKS    = 1'b1
   } csr_index_type;

   // item commands
   typedef enum logic {
      CMD_TICK   = 1'b0,
      CMD_SAMPLE = 1'b1
   } command_type;

   // debouncer phases
   typedef enum logic [1:0] {
      PH_IDLE            = 2'd0,
      PH_MAYBE           = 2'd1,
      PH_PUSHED          = 2'd2,
      PH_MAYBE_FROM_PUSH = 2'd3
   } phase_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [THRESH_W-1:0] press_threshold;
      logic [SETTLE_W-1:0] settle_ticks;
   } csr_type;

endpackage

`default_nettype wire

>>> design/ssd_csr.sv
`default_nettype none

module ssd_csr
   import ssd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output csr_type                    csr_out
);

   csr_type csr_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.press_threshold <= THRESH_RST;
         csr_ff.settle_ticks    <= SETTLE_RST;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PRESS_THRESHOLD: begin
               csr_ff.press_threshold <= csr_write_data[THRESH_W-1:0];
            end
            CSR_SETTLE_TICKS: begin
               csr_ff.settle_ticks <= csr_write_data[SETTLE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_out = csr_ff;

endmodule

`default_nettype wire

>>> design/ssd_in_stage.sv
`default_nettype none

module ssd_in_stage
   import ssd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_command,
   input  wire logic [SAMPLE_BITS-1:0] req_sample_code,
   input  wire logic                   advance,
   output logic                        item_valid,
   output command_type                 item_command,
   output logic [SAMPLE_BITS-1:0]      item_sample
);

   logic                   valid_ff;
   logic                   valid_in;
   command_type            command_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic                   take;

   // stage is free when empty or its beat moves on this cycle
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         command_ff <= command_type'(req_command);
         sample_ff  <= req_sample_code;
      end
   end

   assign item_valid   = valid_ff;
   assign item_command = command_ff;
   assign item_sample  = sample_ff;

endmodule

`default_nettype wire

>>> design/ssd_core.sv
`default_nettype none

module ssd_core
   import ssd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int WAIT_BITS   = WAIT_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire csr_type                csr,
   input  wire logic                   item_valid,
   input  wire command_type            item_command,
   input  wire logic [SAMPLE_BITS-1:0] item_sample,
   output logic                        advance,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_debounced_press,
   output logic                        rsp_led_level,
   output logic [1:0]                  rsp_debounce_phase
);

   phase_type              phase_ff, phase_in;
   logic [WAIT_BITS-1:0]   wait_ff, wait_in;
   logic                   press_ff, press_in;
   logic                   handled_ff, handled_in;
   logic                   led_ff, led_in;

   logic                   rsp_valid_ff;
   logic                   rsp_press_ff;
   logic                   rsp_led_ff;
   phase_type              rsp_phase_ff;

   logic                   fire;
   logic                   pressed;
   logic [SAMPLE_BITS+THRESH_W-1:0] thresh_wide;
   logic [SAMPLE_BITS-1:0]          thresh;
   logic [WAIT_BITS+SETTLE_W-1:0]   settle_wide;
   logic [WAIT_BITS-1:0]            settle;

   // result register loads when empty or its beat is taken
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = item_valid && advance;

   // fit threshold and settle value to the configured widths
   assign thresh_wide = {{SAMPLE_BITS{1'b0}}, csr.press_threshold};
   assign thresh      = thresh_wide[SAMPLE_BITS-1:0];
   assign settle_wide = {{WAIT_BITS{1'b0}}, csr.settle_ticks};
   assign settle      = settle_wide[WAIT_BITS-1:0];
   assign pressed     = item_sample > thresh;

   // next state for one item
   always_comb begin
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      press_in   = press_ff;
      handled_in = handled_ff;
      led_in     = led_ff;
      if (item_command == CMD_TICK) begin
         if (wait_ff != '0) begin
            wait_in = wait_ff - WAIT_BITS'(1);
         end
      end else begin
         if (wait_ff == '0) begin
            wait_in = settle;
            case (phase_ff)
               PH_IDLE: begin
                  phase_in = pressed ? PH_MAYBE : PH_IDLE;
               end
               PH_MAYBE: begin
                  if (pressed) begin
                     phase_in   = PH_PUSHED;
                     press_in   = 1'b1;
                     handled_in = 1'b0;
                  end else begin
                     phase_in = PH_IDLE;
                     press_in = 1'b0;
                  end
               end
               PH_PUSHED: begin
                  phase_in = pressed ? PH_PUSHED : PH_MAYBE_FROM_PUSH;
               end
               PH_MAYBE_FROM_PUSH: begin
                  if (pressed) begin
                     phase_in = PH_PUSHED;
                  end else begin
                     phase_in = PH_IDLE;
                     press_in = 1'b0;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
         // toggle led once per new press
         if (press_in && !handled_in) begin
            handled_in = 1'b1;
            led_in     = !led_ff;
         end
      end
   end

   // debouncer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         wait_ff    <= '0;
         press_ff   <= 1'b0;
         handled_ff <= 1'b0;
         led_ff     <= 1'b0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         wait_ff    <= wait_in;
         press_ff   <= press_in;
         handled_ff <= handled_in;
         led_ff     <= led_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_press_ff <= press_in;
         rsp_led_ff   <= led_in;
         rsp_phase_ff <= phase_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_debounced_press = rsp_press_ff;
   assign rsp_led_level       = rsp_led_ff;
   assign rsp_debounce_phase  = rsp_phase_ff;

endmodule

`default_nettype wire

>>> design/sensor_switch_debouncer_top.sv
// Line-sensor push-button debouncer.
// Request channel (req_valid / req_stall): each beat carries req_command,
// either a timer tick or a sensor sample, and req_sample_code for samples.
// Response channel (rsp_valid / rsp_stall): exactly one beat per request,
// in order, carrying the debounced press flag, the led level and the
// debouncer phase after that request.
// Config port (csr_*): index 0 is the press threshold, index 1 the settle
// tick count; write only while no request is in flight.
// Each request passes the input register, then the result register, on its
// way to a response. Throughput: one request per cycle while the receiver
// does not stall, set by the single state update between the two registers.
// Reset clears the phase, wait counter, press/handled flags and led, empties
// both registers and restores the threshold to 512 and settle count to 20.
// When the receiver stalls, the response holds, the input register keeps its
// beat and req_stall rises while that register is full.
`default_nettype none

module sensor_switch_debouncer_top
   import ssd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int WAIT_BITS   = WAIT_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_command,
   input  wire logic [SAMPLE_BITS-1:0] req_sample_code,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_debounced_press,
   output logic                        rsp_led_level,
   output logic [1:0]                  rsp_debounce_phase,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   csr_type                csr;
   logic                   advance;
   logic                   item_valid;
   command_type            item_command;
   logic [SAMPLE_BITS-1:0] item_sample;

   ssd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr_out          (csr)
   );

   ssd_in_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_in (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_sample_code (req_sample_code),
      .advance         (advance),
      .item_valid      (item_valid),
      .item_command    (item_command),
      .item_sample     (item_sample)
   );

   ssd_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WAIT_BITS   (WAIT_BITS)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .csr                 (csr),
      .item_valid          (item_valid),
      .item_command        (item_command),
      .item_sample         (item_sample),
      .advance             (advance),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_debounced_press (rsp_debounced_press),
      .rsp_led_level       (rsp_led_level),
      .rsp_debounce_phase  (rsp_debounce_phase)
   );

endmodule

`default_nettype wire

>>> design/ssd_checker.sv
`default_nettype none

module ssd_checker
   import ssd_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_debounced_press,
   input wire logic       rsp_led_level,
   input wire logic [1:0] rsp_debounce_phase
);

   // reset empties the response side
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_debounced_press)
         && $stable(rsp_led_level) && $stable(rsp_debounce_phase))
      else $error("stalled response changed");

   // press flag is set exactly in the pushed phases
   a_press_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_debounced_press == rsp_debounce_phase[1]))
      else $error("press flag disagrees with phase");

   // with the response side empty the request side never stalls
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while response empty");

endmodule

bind sensor_switch_debouncer_top ssd_checker u_ssd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_debounced_press (rsp_debounced_press),
   .rsp_led_level       (rsp_led_level),
   .rsp_debounce_phase  (rsp_debounce_phase)
);

`default_nettype wire
